>>> rtl/tbs_pkg.sv
// Shared constants, types and helpers for the temperature batch statistics block.
package tbs_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = 64;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
    localparam int LEVEL_BITS    = 16;
    localparam int READ_BITS     = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OUT_DATA_BITS = 160;

    localparam logic [CFG_IDX_BITS-1:0] REG_WARNING  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CRITICAL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHUTDOWN = 2'd2;

    localparam logic signed [LEVEL_BITS-1:0] WARNING_RESET  = 16'sd480;
    localparam logic signed [LEVEL_BITS-1:0] CRITICAL_RESET = 16'sd720;
    localparam logic signed [LEVEL_BITS-1:0] SHUTDOWN_RESET = 16'sd960;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_WARNING,
        BAND_CRITICAL,
        BAND_SHUTDOWN
    } t_band;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic step_div;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic div_last;
        logic out_full;
    } t_dp_stat;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

endpackage

>>> rtl/temperature_batch_statistics.sv
// Top level of the temperature batch statistics monitor.
// Takes one temperature word per cycle while accumulating a batch: signed 1/16 C
// samples, non-positive ones counted as skipped, positive ones folded into
// min, max, sum, count, four band counters and the first-critical index.
// After the word marked tlast no word is accepted until the divide is done and
// the summary is issued (the divide is skipped when the batch held no valid sample);
// the average comes from the bit-serial restoring divider that forms one quotient
// bit per cycle over the 64-bit sum; the sum keeps growing after the valid
// count saturates, so it is held at full width. The summary sits in
// an output register, so the next batch accumulates while it waits; a new
// summary waits only if the previous one has not been taken.
module temperature_batch_statistics
    import tbs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [LEVEL_BITS-1:0]    i_cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] reading
    input  logic                     s_tlast,   // last_of_batch
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [15:0] valid_count, [31:16] skipped_count, [46:32] min_reading,
    // [61:47] max_reading, [76:62] average_reading, [92:77] first_critical_index,
    // [108:93] normal_count, [124:109] warning_count, [140:125] critical_count,
    // [156:141] shutdown_count, [159:157] zero
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tuser    // empty_batch
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    tbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_reading   (s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .o_m_data    (m_tdata),
        .o_m_user    (m_tuser)
    );

endmodule

>>> rtl/tbs_ctrl.sv
// Control state machine: accumulate, start divide (skipped for an empty batch), divide, emit summary.
module tbs_ctrl
    import tbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        s_tready = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                s_tready     = 1'b1;
                o_cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_stat.empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.load_div = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_stat.div_last) |=> r_state == ST_DIV)
        else $error("divide left early");
    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_stat.out_full) |=> r_state == ST_ACCUM)
        else $error("summary not issued");
`endif

endmodule

>>> rtl/tbs_dp.sv
// Datapath: level registers, batch accumulators, serial divider, output register.
module tbs_dp
    import tbs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [LEVEL_BITS-1:0]      i_cfg_wdata,
    input  logic [15:0]                i_reading,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [OUT_DATA_BITS-1:0]   o_m_data,
    output logic                       o_m_user
);

    logic signed [LEVEL_BITS-1:0] r_warn, r_crit, r_shut;

    logic [COUNT_BITS-1:0] r_cnt_valid, n_cnt_valid;
    logic [COUNT_BITS-1:0] r_cnt_skip, n_cnt_skip;
    logic [COUNT_BITS-1:0] r_first, n_first;
    logic [READ_BITS-1:0]  r_min, n_min;
    logic [READ_BITS-1:0]  r_max, n_max;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_band [4];
    logic [COUNT_BITS-1:0] n_band [4];

    logic [COUNT_BITS:0]     r_rem, n_rem;
    logic [SUM_BITS-1:0]     r_quo, n_quo;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;

    logic                     r_m_valid;
    logic [OUT_DATA_BITS-1:0] r_m_data;
    logic                     r_m_user;

    logic signed [15:0]    rd;
    logic [READ_BITS-1:0]  rd_u;
    logic                  rd_ok;
    logic [COUNT_BITS-1:0] cnt_inc;
    t_band                 band;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  ge;
    logic                  empty;
    logic [READ_BITS-1:0]  o_min, o_max, o_avg;

    // level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn <= WARNING_RESET;
            r_crit <= CRITICAL_RESET;
            r_shut <= SHUTDOWN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WARNING)  r_warn <= i_cfg_wdata;
            if (i_cfg_idx == REG_CRITICAL) r_crit <= i_cfg_wdata;
            if (i_cfg_idx == REG_SHUTDOWN) r_shut <= i_cfg_wdata;
        end
    end

    assign rd      = $signed(i_reading);
    assign rd_u    = i_reading[READ_BITS-1:0];
    assign rd_ok   = rd > 16'sd0;
    assign cnt_inc = sat_inc(r_cnt_valid);
    assign empty   = r_cnt_valid == '0;

    always_comb begin
        priority if (rd < r_warn) begin
            band = BAND_NORMAL;
        end else if (rd < r_crit) begin
            band = BAND_WARNING;
        end else if (rd < r_shut) begin
            band = BAND_CRITICAL;
        end else begin
            band = BAND_SHUTDOWN;
        end
    end

    always_comb begin
        n_cnt_valid = r_cnt_valid;
        n_cnt_skip  = r_cnt_skip;
        n_first     = r_first;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        for (int i = 0; i < 4; i++) begin
            n_band[i] = r_band[i];
        end
        if (i_cmd.accept) begin
            if (!rd_ok) begin
                n_cnt_skip = sat_inc(r_cnt_skip);
            end else begin
                n_cnt_valid = cnt_inc;
                if (empty || rd_u < r_min) n_min = rd_u;
                if (empty || rd_u > r_max) n_max = rd_u;
                n_sum = r_sum + SUM_BITS'(rd_u);
                if (rd >= r_crit && r_first == '0) n_first = cnt_inc;
                n_band[band] = sat_inc(r_band[band]);
            end
        end else if (i_cmd.finish) begin
            n_cnt_valid = '0;
            n_cnt_skip  = '0;
            n_first     = '0;
            n_min       = '0;
            n_max       = '0;
            n_sum       = '0;
            for (int i = 0; i < 4; i++) begin
                n_band[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= '0;
            r_cnt_skip  <= '0;
            r_first     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            for (int i = 0; i < 4; i++) begin
                r_band[i] <= '0;
            end
        end else begin
            r_cnt_valid <= n_cnt_valid;
            r_cnt_skip  <= n_cnt_skip;
            r_first     <= n_first;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            for (int i = 0; i < 4; i++) begin
                r_band[i] <= n_band[i];
            end
        end
    end

    // restoring divider, one quotient bit per step
    assign rem_sh = {r_rem[COUNT_BITS-1:0], r_quo[SUM_BITS-1]};
    assign ge     = rem_sh >= {1'b0, r_cnt_valid};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.load_div) begin
            n_rem = '0;
            n_quo = r_sum;
        end else if (i_cmd.step_div) begin
            n_rem = ge ? rem_sh - {1'b0, r_cnt_valid} : rem_sh;
            n_quo = {r_quo[SUM_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load_div) begin
            r_div_cnt <= '0;
        end else if (i_cmd.step_div) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // output register
    assign o_min = empty ? '0 : r_min;
    assign o_max = empty ? '0 : r_max;
    assign o_avg = empty ? '0 : r_quo[READ_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_m_data <= {3'b000,
                         16'(r_band[BAND_SHUTDOWN]), 16'(r_band[BAND_CRITICAL]),
                         16'(r_band[BAND_WARNING]), 16'(r_band[BAND_NORMAL]),
                         16'(r_first), o_avg, o_max, o_min,
                         16'(r_cnt_skip), 16'(r_cnt_valid)};
            r_m_user <= empty;
        end
    end

    assign o_m_valid       = r_m_valid;
    assign o_m_data        = r_m_data;
    assign o_m_user        = r_m_user;
    assign o_stat.empty    = empty;
    assign o_stat.div_last = r_div_cnt == DIV_CNT_BITS'(SUM_BITS - 1);
    assign o_stat.out_full = r_m_valid && !i_m_ready;

`ifndef ASSERT_OFF
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_min <= r_max)
        else $error("running min above running max");
    a_first_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first <= r_cnt_valid)
        else $error("first critical index beyond valid count");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_cnt_valid == '0 && r_sum == '0 && r_m_valid))
        else $error("summary issue did not clear batch");
`endif

endmodule

>>> test/temperature_batch_statistics_tb.sv
// Self-checking testbench for the temperature batch statistics monitor.
module temperature_batch_statistics_tb;
    import tbs_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 50;
    localparam int N_DIRECTED  = 17;
    localparam int PHASE_WORDS = 300;

    typedef struct packed {
        logic [15:0] valid_cnt;
        logic [15:0] skip_cnt;
        logic [14:0] min_rd;
        logic [14:0] max_rd;
        logic [14:0] avg_rd;
        logic [15:0] first_crit;
        logic [15:0] normal_cnt;
        logic [15:0] warning_cnt;
        logic [15:0] critical_cnt;
        logic [15:0] shutdown_cnt;
        logic        empty;
    } t_summary;

    typedef struct packed {
        logic [15:0] rd;
        logic        last;
        logic        typed;
        t_summary    want;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [LEVEL_BITS-1:0]    i_cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;

    temperature_batch_statistics dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] warn_lvl = WARNING_RESET;
    logic signed [15:0] crit_lvl = CRITICAL_RESET;
    logic signed [15:0] shut_lvl = SHUTDOWN_RESET;
    logic [15:0]        cnt_valid = '0;
    logic [15:0]        cnt_skip = '0;
    logic signed [15:0] lo_rd = '0;
    logic signed [15:0] hi_rd = '0;
    longint unsigned    sum_acc = 0;
    logic [15:0]        first_idx = '0;
    logic [15:0]        band_cnt [4] = '{default: '0};

    t_summary  summary_q [$];
    t_stim_row dir_rows [N_DIRECTED];
    int        err_cnt = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        stall_left = 0;
    bit        tx_gaps = 1'b1;
    int        rx_mode = 1;

    function automatic logic [15:0] bump(logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    function automatic void apply_level(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        case (idx)
            REG_WARNING:  warn_lvl = val;
            REG_CRITICAL: crit_lvl = val;
            REG_SHUTDOWN: shut_lvl = val;
            default: ;
        endcase
    endfunction

    function automatic bit fold_sample(logic signed [15:0] rd, bit last, output t_summary s);
        bit    first;
        t_band b;
        s = '0;
        if (rd <= 0) begin
            cnt_skip = bump(cnt_skip);
        end else begin
            first = (cnt_valid == 0);
            cnt_valid = bump(cnt_valid);
            if (first || rd < lo_rd) lo_rd = rd;
            if (first || rd > hi_rd) hi_rd = rd;
            sum_acc += {48'd0, rd};
            if (rd >= crit_lvl && first_idx == 0) first_idx = cnt_valid;
            if (rd < warn_lvl) b = BAND_NORMAL;
            else if (rd < crit_lvl) b = BAND_WARNING;
            else if (rd < shut_lvl) b = BAND_CRITICAL;
            else b = BAND_SHUTDOWN;
            band_cnt[b] = bump(band_cnt[b]);
        end
        if (!last) return 1'b0;
        s.valid_cnt = cnt_valid;
        s.skip_cnt  = cnt_skip;
        if (cnt_valid == 0) begin
            s.empty = 1'b1;
        end else begin
            s.min_rd = lo_rd[14:0];
            s.max_rd = hi_rd[14:0];
            s.avg_rd = 15'(sum_acc / cnt_valid);
        end
        s.first_crit   = first_idx;
        s.normal_cnt   = band_cnt[BAND_NORMAL];
        s.warning_cnt  = band_cnt[BAND_WARNING];
        s.critical_cnt = band_cnt[BAND_CRITICAL];
        s.shutdown_cnt = band_cnt[BAND_SHUTDOWN];
        cnt_valid = '0;
        cnt_skip  = '0;
        lo_rd     = '0;
        hi_rd     = '0;
        sum_acc   = 0;
        first_idx = '0;
        band_cnt  = '{default: '0};
        return 1'b1;
    endfunction

    function automatic t_summary summ(int vc, int sc, int mn, int mx, int av, int fc,
                                      int nc, int wc, int cc, int dc, int e);
        return '{16'(vc), 16'(sc), 15'(mn), 15'(mx), 15'(av), 16'(fc),
                 16'(nc), 16'(wc), 16'(cc), 16'(dc), 1'(e)};
    endfunction

    function automatic logic [15:0] pick_reading();
        int lvl;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(-int'($urandom_range(0, 32768)));
            2, 3: begin
                case ($urandom_range(0, 2))
                    0: lvl = int'(warn_lvl);
                    1: lvl = int'(crit_lvl);
                    default: lvl = int'(shut_lvl);
                endcase
                return 16'(lvl + int'($urandom_range(0, 8)) - 4);
            end
            4: return $urandom_range(0, 1) ? 16'h7FFF : 16'h0001;
            default: return 16'($urandom_range(1, 1500));
        endcase
    endfunction

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic pace_sender();
        int gap;
        if (!tx_gaps) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] rd, bit last, bit typed, t_summary want);
        t_summary pred;
        s_tvalid <= 1'b1;
        s_tdata  <= rd;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        if (fold_sample(rd, last, pred)) summary_q.push_back(typed ? want : pred);
        pace_sender();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        apply_level(idx, val);
    endtask

    task automatic program_levels(logic [15:0] w, logic [15:0] c, logic [15:0] d, bit poke);
        write_reg(REG_WARNING, w);
        write_reg(REG_CRITICAL, c);
        write_reg(REG_SHUTDOWN, d);
        if (poke) write_reg(REG_UNUSED, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // receiver stall pattern: mode 0 always ready, 1 short stalls, 2 long stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (rx_mode == 0 || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= $urandom_range(1, (rx_mode == 2) ? 40 : 4);
            m_tready   <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_summary got;
        t_summary want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[46:32], m_tdata[61:47],
                    m_tdata[76:62], m_tdata[92:77], m_tdata[108:93], m_tdata[124:109],
                    m_tdata[140:125], m_tdata[156:141], m_tuser};
            if (summary_q.size() == 0) begin
                $error("summary word with none expected");
                err_cnt++;
            end else begin
                want = summary_q.pop_front();
                cmp_field("valid_count", want.valid_cnt, got.valid_cnt);
                cmp_field("skipped_count", want.skip_cnt, got.skip_cnt);
                cmp_field("min_reading", 16'(want.min_rd), 16'(got.min_rd));
                cmp_field("max_reading", 16'(want.max_rd), 16'(got.max_rd));
                cmp_field("average_reading", 16'(want.avg_rd), 16'(got.avg_rd));
                cmp_field("first_critical_index", want.first_crit, got.first_crit);
                cmp_field("normal_count", want.normal_cnt, got.normal_cnt);
                cmp_field("warning_count", want.warning_cnt, got.warning_cnt);
                cmp_field("critical_count", want.critical_cnt, got.critical_cnt);
                cmp_field("shutdown_count", want.shutdown_cnt, got.shutdown_cnt);
                cmp_field("empty_batch", 16'(want.empty), 16'(got.empty));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          p;
        int          k;
        int          blen;
        int          sent;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] t;

        // empty batches, extremes, every band edge, truncating average
        dir_rows[0]  = '{16'h0000, 1'b1, 1'b1, summ(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir_rows[1]  = '{16'h8000, 1'b1, 1'b1, summ(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir_rows[2]  = '{16'h7FFF, 1'b1, 1'b1,
                         summ(1, 0, 32767, 32767, 32767, 1, 0, 0, 0, 1, 0)};
        dir_rows[3]  = '{16'h0001, 1'b1, 1'b1, summ(1, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0)};
        dir_rows[4]  = '{16'd479, 1'b0, 1'b0, '0};
        dir_rows[5]  = '{16'd480, 1'b0, 1'b0, '0};
        dir_rows[6]  = '{16'd719, 1'b0, 1'b0, '0};
        dir_rows[7]  = '{16'd720, 1'b0, 1'b0, '0};
        dir_rows[8]  = '{16'd959, 1'b0, 1'b0, '0};
        dir_rows[9]  = '{16'd960, 1'b0, 1'b0, '0};
        dir_rows[10] = '{16'hFFFF, 1'b0, 1'b0, '0};
        dir_rows[11] = '{16'd1, 1'b1, 1'b0, '0};
        dir_rows[12] = '{16'd100, 1'b0, 1'b0, '0};
        dir_rows[13] = '{16'd101, 1'b0, 1'b0, '0};
        dir_rows[14] = '{16'd102, 1'b1, 1'b0, '0};
        dir_rows[15] = '{16'd1, 1'b0, 1'b0, '0};
        dir_rows[16] = '{16'd2, 1'b1, 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_sample(dir_rows[i].rd, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        for (p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: program_levels(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
                1: program_levels(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
                2, 4: program_levels(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
                3: begin
                    a = 16'($urandom_range(1, 2000));
                    b = 16'($urandom_range(1, 2000));
                    c = 16'($urandom_range(1, 2000));
                    if (a > b) begin t = a; a = b; b = t; end
                    if (b > c) begin t = b; b = c; c = t; end
                    if (a > b) begin t = a; a = b; b = t; end
                    program_levels(a, b, c, 1'b0);
                end
                default: program_levels(WARNING_RESET, CRITICAL_RESET, SHUTDOWN_RESET, 1'b0);
            endcase
            tx_gaps = (p % 2 == 0);
            rx_mode = p % 3;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                blen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                for (k = 0; k < blen; k++)
                    send_sample(pick_reading(), k == blen - 1, 1'b0, '0);
                sent += blen;
            end
        end

        settle();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/tbs_pkg.sv
rtl/tbs_ctrl.sv
rtl/tbs_dp.sv
rtl/temperature_batch_statistics.sv
test/temperature_batch_statistics_tb.sv
